FILE: rtl/hvac_ir_pkg.sv
// Package: shared constants, code tables and helpers of the IR frame transmitter.
package hvac_ir_pkg;

    // Tick counts of the envelope durations.
    localparam int TICK_W = 16;

    // Timing register file
    localparam int NUM_REGS = 7;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_HEADER_MARK   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEADER_SPACE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BIT_MARK      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ONE_SPACE     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_SPACE    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TRAILER_MARK  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TRAILER_SPACE = 3'd6;

    localparam logic [TICK_W-1:0] RST_HEADER_MARK   = 16'd4400;
    localparam logic [TICK_W-1:0] RST_HEADER_SPACE  = 16'd4300;
    localparam logic [TICK_W-1:0] RST_BIT_MARK      = 16'd543;
    localparam logic [TICK_W-1:0] RST_ONE_SPACE     = 16'd1623;
    localparam logic [TICK_W-1:0] RST_ZERO_SPACE    = 16'd472;
    localparam logic [TICK_W-1:0] RST_TRAILER_MARK  = 16'd440;
    localparam logic [TICK_W-1:0] RST_TRAILER_SPACE = 16'd7048;

    // Frame geometry defaults
    localparam int FRAME_BYTES_DEF   = 9;
    localparam int FRAME_REPEATS_DEF = 2;

    // Request opcodes
    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    // Mode codes
    localparam logic [2:0] MODE_HOT  = 3'd0;
    localparam logic [2:0] MODE_COLD = 3'd1;
    localparam logic [2:0] MODE_DRY  = 3'd2;
    localparam logic [2:0] MODE_AUTO = 3'd3;

    // Fan codes
    localparam logic [2:0] FAN_AUTO    = 3'd0;
    localparam logic [2:0] FAN_SPEED1  = 3'd1;
    localparam logic [2:0] FAN_SPEED2  = 3'd2;
    localparam logic [2:0] FAN_SPEED3  = 3'd3;
    localparam logic [2:0] FAN_SPEED4  = 3'd4;
    localparam logic [2:0] FAN_SPEED5  = 3'd5;
    localparam logic [2:0] FAN_SILENT  = 3'd6;
    localparam logic [2:0] FAN_INVALID = 3'd7;

    // Frame contents
    localparam int PREFIX_LEN = 5;
    localparam logic [7:0] PREFIX_BYTES [PREFIX_LEN] = '{8'hF2, 8'h0D, 8'h03, 8'hFC, 8'h01};
    localparam int TEMP_BYTE_POS = 5;
    localparam int MODE_BYTE_POS = 6;
    localparam logic [7:0] OFF_MODE_BITS = 8'h07;
    localparam logic signed [7:0] TEMP_MIN = 8'sd17;
    localparam logic signed [7:0] TEMP_MAX = 8'sd30;

    typedef logic [TICK_W-1:0] tick_t;

    function automatic logic [7:0] mode_bits(input logic [2:0] mode);
        logic [7:0] v;
        case (mode)
            MODE_HOT:  v = 8'h03;
            MODE_COLD: v = 8'h01;
            MODE_DRY:  v = 8'h02;
            MODE_AUTO: v = 8'h00;
            default:   v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] fan_bits(input logic [2:0] fan);
        logic [7:0] v;
        case (fan)
            FAN_AUTO:   v = 8'h00;
            FAN_SPEED1: v = 8'h40;
            FAN_SPEED2: v = 8'h60;
            FAN_SPEED3: v = 8'h80;
            FAN_SPEED4: v = 8'hA0;
            FAN_SPEED5: v = 8'hC0;
            FAN_SILENT: v = 8'h00;
            default:    v = 8'h00;
        endcase
        return v;
    endfunction

    // Reverse bit order so that the first bit sent lands at bit 0.
    function automatic logic [7:0] bit_rev(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

    // Zero durations count as one tick.
    function automatic tick_t min_one(input tick_t v);
        return (v == '0) ? tick_t'(1) : v;
    endfunction

endpackage

FILE: rtl/hvac_ir_frame_transmitter_core.sv
// Top level: air-conditioner IR frame builder and pulse-distance envelope sequencer.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  s_      | in        | s_valid / s_ready  | action, mode_code, fan_code, set_temp, power_off
//  m_      | out       | m_valid / m_ready  | led_on, busy_res, accepted, param_error,
//          |           |                    | sequence_done
//  cfg_    | in        | cfg_we             | cfg_index, cfg_data (timing registers)
//
//  One request is taken per cycle while s_ready is high; its result appears in the output
//  register on the next cycle, set by the single state/result register stage.
//  s_ready drops only while a result waits in the output register and m_ready is low.
//  aresetn (synchronous, active low) idles the sequencer and loads default timings;
//  the frame store holds no reset value and is always written by a load before use.
module hvac_ir_frame_transmitter_core #(
    parameter int FRAME_BYTES   = hvac_ir_pkg::FRAME_BYTES_DEF,
    parameter int FRAME_REPEATS = hvac_ir_pkg::FRAME_REPEATS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_action,
    input  logic [2:0]                           s_mode_code,
    input  logic [2:0]                           s_fan_code,
    input  logic signed [7:0]                    s_set_temp,
    input  logic                                 s_power_off,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_led_on,
    output logic                                 m_busy_res,
    output logic                                 m_accepted,
    output logic                                 m_param_error,
    output logic                                 m_sequence_done,

    input  logic                                 cfg_we,
    input  logic [hvac_ir_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [hvac_ir_pkg::TICK_W-1:0]       cfg_data
);

    // Segment layout of one pass: header mark/space, mark+space per bit, trailer mark/space.
    localparam int NBITS     = 8 * FRAME_BYTES;
    localparam int BIT_W     = $clog2(NBITS);
    localparam int SEG_COUNT = 4 + 2 * NBITS;
    localparam int SEG_W     = $clog2(SEG_COUNT);
    localparam int PASS_W    = (FRAME_REPEATS > 1) ? $clog2(FRAME_REPEATS) : 1;

    localparam logic [SEG_W-1:0]  SEG_LAST      = SEG_W'(SEG_COUNT - 1);
    localparam logic [SEG_W-1:0]  SEG_TRL_MARK  = SEG_W'(SEG_COUNT - 2);
    localparam logic [SEG_W-1:0]  SEG_HDR_MARK  = SEG_W'(0);
    localparam logic [SEG_W-1:0]  SEG_HDR_SPACE = SEG_W'(1);
    localparam logic [SEG_W-1:0]  SEG_FIRST_BIT = SEG_W'(2);
    localparam logic [PASS_W-1:0] PASS_LAST     = PASS_W'(FRAME_REPEATS - 1);

    // ------------------------------------------------------------------
    // Timing registers
    // ------------------------------------------------------------------
    hvac_ir_pkg::tick_t hdr_mark_reg, hdr_space_reg, bit_mark_reg;
    hvac_ir_pkg::tick_t one_space_reg, zero_space_reg, trl_mark_reg, trl_space_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_mark_reg   <= hvac_ir_pkg::RST_HEADER_MARK;
            hdr_space_reg  <= hvac_ir_pkg::RST_HEADER_SPACE;
            bit_mark_reg   <= hvac_ir_pkg::RST_BIT_MARK;
            one_space_reg  <= hvac_ir_pkg::RST_ONE_SPACE;
            zero_space_reg <= hvac_ir_pkg::RST_ZERO_SPACE;
            trl_mark_reg   <= hvac_ir_pkg::RST_TRAILER_MARK;
            trl_space_reg  <= hvac_ir_pkg::RST_TRAILER_SPACE;
        end else if (cfg_we) begin
            // Drop writes beyond the last register.
            case (cfg_index)
                hvac_ir_pkg::REG_HEADER_MARK:   hdr_mark_reg   <= cfg_data;
                hvac_ir_pkg::REG_HEADER_SPACE:  hdr_space_reg  <= cfg_data;
                hvac_ir_pkg::REG_BIT_MARK:      bit_mark_reg   <= cfg_data;
                hvac_ir_pkg::REG_ONE_SPACE:     one_space_reg  <= cfg_data;
                hvac_ir_pkg::REG_ZERO_SPACE:    zero_space_reg <= cfg_data;
                hvac_ir_pkg::REG_TRAILER_MARK:  trl_mark_reg   <= cfg_data;
                hvac_ir_pkg::REG_TRAILER_SPACE: trl_space_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [NBITS-1:0]    frame_reg, frame_next;   // bit j is the j-th data bit sent
    logic [SEG_W-1:0]    seg_reg, seg_next;
    hvac_ir_pkg::tick_t  time_left_reg, time_left_next;
    logic [PASS_W-1:0]   pass_reg, pass_next;
    logic                busy_reg, busy_next;
    logic                error_reg, error_next;

    // Output register
    logic m_valid_reg, m_valid_next;
    logic led_reg, led_next;
    logic busy_res_reg;
    logic accepted_reg, accepted_next;
    logic param_error_reg;
    logic done_reg, done_next;

    logic s_fire;
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Frame builder: prefix, clamped temperature, mode/fan byte, zero fill, XOR check
    // ------------------------------------------------------------------
    logic signed [7:0] temp_clamped;
    logic [7:0]        temp_byte;
    logic [7:0]        mf_byte;
    logic              load_err;
    logic [7:0]        chk;
    logic [7:0]        fbyte;
    logic [NBITS-1:0]  frame_built;

    always_comb begin
        if (s_set_temp > hvac_ir_pkg::TEMP_MAX) begin
            temp_clamped = hvac_ir_pkg::TEMP_MAX;
        end else if (s_set_temp < hvac_ir_pkg::TEMP_MIN) begin
            temp_clamped = hvac_ir_pkg::TEMP_MIN;
        end else begin
            temp_clamped = s_set_temp;
        end
        temp_byte = {4'(temp_clamped - hvac_ir_pkg::TEMP_MIN), 4'h0};

        load_err = 1'b0;
        mf_byte  = hvac_ir_pkg::mode_bits(s_mode_code);
        if (s_mode_code[2]) begin
            load_err = 1'b1;
        end
        if (s_power_off) begin
            mf_byte = hvac_ir_pkg::OFF_MODE_BITS;
        end
        mf_byte = mf_byte | hvac_ir_pkg::fan_bits(s_fan_code);
        if (s_fan_code == hvac_ir_pkg::FAN_INVALID) begin
            load_err = 1'b1;
        end

        chk         = 8'h00;
        frame_built = '0;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if (i < hvac_ir_pkg::PREFIX_LEN) begin
                fbyte = hvac_ir_pkg::PREFIX_BYTES[3'(i)];
            end else if (i == hvac_ir_pkg::TEMP_BYTE_POS) begin
                fbyte = temp_byte;
            end else if (i == hvac_ir_pkg::MODE_BYTE_POS) begin
                fbyte = mf_byte;
            end else begin
                fbyte = 8'h00;
            end
            if (i == FRAME_BYTES - 1) begin
                fbyte = chk;
            end else begin
                chk = chk ^ fbyte;
            end
            frame_built[8*i +: 8] = hvac_ir_pkg::bit_rev(fbyte);
        end
    end

    // ------------------------------------------------------------------
    // Duration of the segment that starts when the current one runs out
    // ------------------------------------------------------------------
    logic [SEG_W-1:0]   seg_adv;
    logic [SEG_W-1:0]   bit_seg;
    logic [SEG_W-2:0]   bit_pos;
    hvac_ir_pkg::tick_t dur_raw;

    always_comb begin
        seg_adv = (seg_reg == SEG_LAST) ? '0 : seg_reg + SEG_W'(1);
        bit_seg = seg_adv - SEG_FIRST_BIT;
        bit_pos = bit_seg[SEG_W-1:1];
        if (seg_adv == SEG_HDR_MARK) begin
            dur_raw = hdr_mark_reg;
        end else if (seg_adv == SEG_HDR_SPACE) begin
            dur_raw = hdr_space_reg;
        end else if (seg_adv == SEG_TRL_MARK) begin
            dur_raw = trl_mark_reg;
        end else if (seg_adv == SEG_LAST) begin
            dur_raw = trl_space_reg;
        end else if (!bit_seg[0]) begin
            dur_raw = bit_mark_reg;
        end else if (frame_reg[bit_pos[BIT_W-1:0]]) begin
            dur_raw = one_space_reg;
        end else begin
            dur_raw = zero_space_reg;
        end
    end

    // ------------------------------------------------------------------
    // Next state and result
    // ------------------------------------------------------------------
    always_comb begin
        frame_next     = frame_reg;
        seg_next       = seg_reg;
        time_left_next = time_left_reg;
        pass_next      = pass_reg;
        busy_next      = busy_reg;
        error_next     = error_reg;
        led_next       = led_reg;
        accepted_next  = accepted_reg;
        done_next      = done_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        if (s_fire) begin
            m_valid_next  = 1'b1;
            led_next      = 1'b0;
            accepted_next = 1'b0;
            done_next     = 1'b0;
            if (s_action == hvac_ir_pkg::ACTION_LOAD) begin
                // Refuse a load while a sequence is on air.
                if (!busy_reg) begin
                    frame_next     = frame_built;
                    error_next     = load_err;
                    busy_next      = 1'b1;
                    pass_next      = '0;
                    seg_next       = '0;
                    time_left_next = hvac_ir_pkg::min_one(hdr_mark_reg);
                    accepted_next  = 1'b1;
                end
            end else if (busy_reg) begin
                // Marks sit on even segments.
                led_next = !seg_reg[0];
                if (time_left_reg > hvac_ir_pkg::tick_t'(1)) begin
                    time_left_next = time_left_reg - hvac_ir_pkg::tick_t'(1);
                end else if (seg_reg == SEG_LAST && pass_reg == PASS_LAST) begin
                    busy_next      = 1'b0;
                    pass_next      = '0;
                    seg_next       = '0;
                    time_left_next = '0;
                    done_next      = 1'b1;
                end else begin
                    if (seg_reg == SEG_LAST) begin
                        pass_next = pass_reg + PASS_W'(1);
                    end
                    seg_next       = seg_adv;
                    time_left_next = hvac_ir_pkg::min_one(dur_raw);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg       <= '0;
            time_left_reg <= '0;
            pass_reg      <= '0;
            busy_reg      <= 1'b0;
            error_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            seg_reg       <= seg_next;
            time_left_reg <= time_left_next;
            pass_reg      <= pass_next;
            busy_reg      <= busy_next;
            error_reg     <= error_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload: frame store and result fields, no reset.
    always_ff @(posedge aclk) begin
        frame_reg       <= frame_next;
        led_reg         <= led_next;
        accepted_reg    <= accepted_next;
        done_reg        <= done_next;
        if (s_fire) begin
            busy_res_reg    <= busy_next;
            param_error_reg <= error_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_led_on        = led_reg;
    assign m_busy_res      = busy_res_reg;
    assign m_accepted      = accepted_reg;
    assign m_param_error   = param_error_reg;
    assign m_sequence_done = done_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_parked: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (seg_reg == '0) && (pass_reg == '0))
        else $error("idle sequencer not parked at first segment");

    a_busy_time: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (time_left_reg != '0))
        else $error("running segment with zero ticks left");

    a_seg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_reg <= SEG_LAST)
        else $error("segment index past end of pass");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_action == hvac_ir_pkg::ACTION_TICK && busy_reg && !busy_next)
        |=> m_valid && m_sequence_done && !m_busy_res)
        else $error("end of final pass not reported");

    a_load_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accepted) |-> !m_led_on && !m_sequence_done && m_busy_res)
        else $error("accepted load reported with envelope activity");

endmodule
